// File: hw/rtl/smpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the stable minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int ID_W     = 8;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int LIMIT_W  = 5;

   localparam logic [LIMIT_W-1:0] SEAT_LIMIT_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_REMOVED  = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] priority_value;
      logic [ID_W-1:0]   requester_id;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_PLACE,
      ST_REMOVE
   } state_type;

endpackage
`default_nettype wire

// File: hw/rtl/smpq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smpq_store #(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [PTR_W-1:0]   wr_addr,
   input  wire smpq_pkg::entry_type wr_data,
   input  wire logic [PTR_W-1:0]   rd_addr,
   output smpq_pkg::entry_type     rd_data
);
   import smpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/smpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer: circular store pointers, insertion scan from the tail with
// shift-up, head removal, and the registered response word.
// ----------------------------------------------------------------------------
module smpq_ctrl #(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4,
   parameter int CNT_W = 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_operation,
   input  wire logic [smpq_pkg::ID_W-1:0]    req_requester_id,
   input  wire logic [smpq_pkg::PRIO_W-1:0]  req_priority_value,
   input  wire logic [smpq_pkg::LIMIT_W-1:0] seat_limit,
   output logic                              mem_wr_en,
   output logic [PTR_W-1:0]                  mem_wr_addr,
   output smpq_pkg::entry_type               mem_wr_data,
   output logic [PTR_W-1:0]                  mem_rd_addr,
   input  wire smpq_pkg::entry_type          mem_rd_data,
   output logic                              rsp_strobe,
   output logic [smpq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [smpq_pkg::ID_W-1:0]         rsp_served_id,
   output logic [smpq_pkg::PRIO_W-1:0]       rsp_served_priority,
   output logic [smpq_pkg::OCC_W-1:0]        rsp_occupancy
);
   import smpq_pkg::*;

   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] scan_ff, scan_in;
   logic [PTR_W-1:0] place_ff, place_in;
   entry_type        new_ff, new_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic accept;
   logic full;
   logic scan_at_head;
   logic shift_up;

   assign accept       = start && (state_ff == ST_IDLE);
   assign full         = (CMP_W'(count_ff) >= CMP_W'(seat_limit))
                         || (count_ff == CNT_W'(DEPTH));
   assign scan_at_head = (scan_ff == head_ff);
   assign shift_up     = (mem_rd_data.priority_value > new_ff.priority_value);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_INSERT) begin
                  if (full) begin
                     state_in = ST_IDLE;
                  end else if (count_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end else if (count_ff != '0) begin
                  state_in = ST_REMOVE;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (shift_up && !scan_at_head) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = ST_IDLE;
         end
         ST_REMOVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      place_in      = place_ff;
      new_in        = new_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = place_ff;
      mem_wr_data   = new_ff;
      mem_rd_addr   = (state_ff == ST_SCAN_RD) ? scan_ff : head_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in.requester_id   = req_requester_id;
               new_in.priority_value = req_priority_value;
               rsp_id_in             = '0;
               rsp_prio_in           = '0;
               rsp_occ_in            = OCC_W'(count_ff);
               if (req_operation == OP_INSERT) begin
                  if (full) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_REJECTED;
                  end else begin
                     place_in = tail_ff;
                     scan_in  = ptr_prev(tail_ff);
                  end
               end else if (count_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         ST_SCAN_RD: begin
         end
         ST_SCAN_CMP: begin
            if (shift_up) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ptr_next(scan_ff);
               mem_wr_data = mem_rd_data;
               place_in    = scan_ff;
               scan_in     = ptr_prev(scan_ff);
            end else begin
               place_in = ptr_next(scan_ff);
            end
         end
         ST_PLACE: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = place_ff;
            mem_wr_data   = new_ff;
            tail_in       = ptr_next(tail_ff);
            count_in      = count_ff + 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_INSERTED;
            rsp_id_in     = '0;
            rsp_prio_in   = '0;
            rsp_occ_in    = OCC_W'(count_ff + 1'b1);
         end
         ST_REMOVE: begin
            head_in       = ptr_next(head_ff);
            count_in      = count_ff - 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_REMOVED;
            rsp_id_in     = mem_rd_data.requester_id;
            rsp_prio_in   = mem_rd_data.priority_value;
            rsp_occ_in    = OCC_W'(count_ff - 1'b1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      place_ff      <= place_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_served_id       = rsp_id_ff;
   assign rsp_served_priority = rsp_prio_ff;
   assign rsp_occupancy       = rsp_occ_ff;

endmodule
`default_nettype wire

// File: hw/rtl/stable_min_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Request scheduler holding up to DEPTH requests sorted by ascending
// priority value, equal values in arrival order.
//
// Request channel: a word (req_operation, req_requester_id,
// req_priority_value) is taken on a clock edge with start high and busy low.
// Operation insert places the request behind every waiting entry of equal or
// lower value; operation remove hands out the head entry.
// Response channel: one word per request, shown for one cycle with
// rsp_strobe high; the receiver has no way to stall it.
// Configuration: csr_wr_en writes csr_wr_data into the seat limit at once.
// Reject and empty-remove answer from the idle state; remove reads the
// head entry, then answers; insert scans from the tail toward the head,
// each visited entry passing a read and a compare state that moves it up
// one slot if its value is higher, stops at the first entry of equal or
// lower value or at the head (no scan when empty), then places the entry
// and answers. Busy stays high until the response is shown.
// Reset (synchronous) empties the queue and sets the seat limit to 16; the
// entry memory is not cleared; read data is used only from occupied slots.
// ----------------------------------------------------------------------------
module stable_min_priority_queue #(
   parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_operation,
   input  wire logic [smpq_pkg::ID_W-1:0]     req_requester_id,
   input  wire logic [smpq_pkg::PRIO_W-1:0]   req_priority_value,
   output logic                               rsp_strobe,
   output logic [smpq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [smpq_pkg::ID_W-1:0]          rsp_served_id,
   output logic [smpq_pkg::PRIO_W-1:0]        rsp_served_priority,
   output logic [smpq_pkg::OCC_W-1:0]         rsp_occupancy,
   input  wire logic                          csr_wr_en,
   input  wire logic [smpq_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import smpq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [LIMIT_W-1:0] seat_limit_ff;
   logic               mem_wr_en;
   logic [PTR_W-1:0]   mem_wr_addr;
   entry_type          mem_wr_data;
   logic [PTR_W-1:0]   mem_rd_addr;
   entry_type          mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         seat_limit_ff <= SEAT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         seat_limit_ff <= csr_wr_data;
      end
   end

   smpq_store #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   smpq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_requester_id    (req_requester_id),
      .req_priority_value  (req_priority_value),
      .seat_limit          (seat_limit_ff),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_served_id       (rsp_served_id),
      .rsp_served_priority (rsp_served_priority),
      .rsp_occupancy       (rsp_occupancy)
   );

endmodule
`default_nettype wire
